@@ design/rs_pkg.sv @@
// shared constants, types and state encodings of the reservoir sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rs_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = 6;
    localparam int SIZE_W = 7;
    localparam int TAG_W  = 32;
    localparam int SEEN_W = 32;

    localparam int MT_N   = 624;
    localparam int MT_M   = 397;
    localparam int MT_AW  = 10;

    localparam logic [31:0] MT_DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] MT_INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX       = 32'h9908B0DF;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd1;

    typedef enum logic [0:0] {
        REG_SAMPLE_SIZE = 1'b0,
        REG_RNG_SEED    = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_OFFER = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MID,
        D_MIX
    } draw_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW,
        S_DIV,
        S_EMIT,
        S_FLUSH_RD,
        S_FLUSH_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic seed_load;
        logic draw_req;
    } tw_ctrl_t;

    typedef struct packed {
        logic busy;
        logic word_valid;
    } tw_stat_t;

endpackage

`default_nettype wire

@@ design/rs_twister.sv @@
// mt19937 generator: 624-word state memory, sequential seeding and
// per-draw in-place twist with tempering; uses rs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rs_twister (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  rs_pkg::tw_ctrl_t      ctrl,
    input  wire logic [31:0]      seed,
    output rs_pkg::tw_stat_t      stat,
    output logic      [31:0]      word
);
    import rs_pkg::*;

    logic [31:0] mt_mem [MT_N];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    logic              seeding_reg;
    logic [MT_AW-1:0]  seed_idx_reg;
    logic [31:0]       prev_reg;
    logic [MT_AW-1:0]  pos_reg;
    draw_state_t       dstate_reg, dstate_next;
    logic [31:0]       y_reg;
    logic [31:0]       word_reg;
    logic              word_valid_reg;

    logic [31:0]       seed_word;
    logic [31:0]       mix_word;
    logic [MT_AW-1:0]  pos_plus1;
    logic [MT_AW-1:0]  pos_plus_m;
    logic [MT_AW-1:0]  addr_b;
    logic              mem_we;
    logic [MT_AW-1:0]  mem_waddr;
    logic [31:0]       mem_wdata;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x >> 11);
        t = t ^ ((t << 7) & 32'h9D2C5680);
        t = t ^ ((t << 15) & 32'hEFC60000);
        t = t ^ (t >> 18);
        return t;
    endfunction

    assign seed_word = (seed_idx_reg == '0) ? prev_reg :
        32'(MT_INIT_MULT * (prev_reg ^ (prev_reg >> 30))) + {22'd0, seed_idx_reg};

    assign mix_word = rd_b_reg ^ (y_reg >> 1) ^ (y_reg[0] ? MT_MATRIX : 32'd0);

    assign pos_plus1  = (pos_reg == MT_AW'(MT_N - 1)) ? '0 : pos_reg + 1'b1;
    assign pos_plus_m = (pos_reg >= MT_AW'(MT_N - MT_M)) ? pos_reg - MT_AW'(MT_N - MT_M)
                                                         : pos_reg + MT_AW'(MT_M);
    // first read pair is w[p] and w[p+1], then w[p+m] on port b
    assign addr_b = (dstate_reg == D_IDLE) ? pos_plus1 : pos_plus_m;

    assign mem_we    = seeding_reg || (dstate_reg == D_MIX);
    assign mem_waddr = seeding_reg ? seed_idx_reg : pos_reg;
    assign mem_wdata = seeding_reg ? seed_word : mix_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mt_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mt_mem[pos_reg];
        rd_b_reg <= mt_mem[addr_b];
    end

    always_comb
    begin
        dstate_next = dstate_reg;
        unique case (dstate_reg)
            D_IDLE:
            begin
                if (ctrl.draw_req)
                begin
                    dstate_next = D_MID;
                end
            end
            D_MID:   dstate_next = D_MIX;
            D_MIX:   dstate_next = D_IDLE;
            default: dstate_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeding_reg    <= 1'b1;
            seed_idx_reg   <= '0;
            prev_reg       <= MT_DEFAULT_SEED;
            pos_reg        <= '0;
            dstate_reg     <= D_IDLE;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            word_valid_reg <= (dstate_reg == D_MIX);
            if (ctrl.seed_load)
            begin
                seeding_reg  <= 1'b1;
                seed_idx_reg <= '0;
                prev_reg     <= seed;
                pos_reg      <= '0;
                dstate_reg   <= D_IDLE;
            end
            else
            begin
                dstate_reg <= dstate_next;
                if (seeding_reg)
                begin
                    prev_reg <= seed_word;
                    if (seed_idx_reg == MT_AW'(MT_N - 1))
                    begin
                        seeding_reg <= 1'b0;
                    end
                    else
                    begin
                        seed_idx_reg <= seed_idx_reg + 1'b1;
                    end
                end
                if (dstate_reg == D_MIX)
                begin
                    pos_reg <= pos_plus1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dstate_reg == D_MID)
        begin
            y_reg <= {rd_a_reg[31], rd_b_reg[30:0]};
        end
        if (dstate_reg == D_MIX)
        begin
            word_reg <= temper(mix_word);
        end
    end

    assign stat.busy       = seeding_reg;
    assign stat.word_valid = word_valid_reg;
    assign word            = word_reg;

endmodule

`default_nettype wire

@@ design/rs_divider.sv @@
// radix-2 restoring remainder unit, two lanes sharing one dividend:
// r mod (seen+1) and r mod size, one bit per cycle; uses rs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rs_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [31:0]                 dividend,
    input  wire logic [32:0]                 modulus,
    input  wire logic [rs_pkg::SIZE_W-1:0]   size,
    output logic                             done,
    output logic      [32:0]                 rem_seen,
    output logic      [rs_pkg::SIZE_W-1:0]   rem_size
);
    import rs_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [31:0]       quo_reg;
    logic [32:0]       r1_reg;
    logic [SIZE_W-1:0] r2_reg;
    logic [32:0]       d1_reg;
    logic [SIZE_W-1:0] d2_reg;

    logic [33:0]       t1;
    logic [SIZE_W:0]   t2;
    logic [32:0]       r1_next;
    logic [SIZE_W-1:0] r2_next;

    always_comb
    begin
        t1 = {r1_reg, quo_reg[31]};
        t2 = {r2_reg, quo_reg[31]};
        if (t1 >= {1'b0, d1_reg})
        begin
            r1_next = 33'(t1 - {1'b0, d1_reg});
        end
        else
        begin
            r1_next = t1[32:0];
        end
        if (t2 >= {1'b0, d2_reg})
        begin
            r2_next = SIZE_W'(t2 - {1'b0, d2_reg});
        end
        else
        begin
            r2_next = t2[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            r1_reg  <= '0;
            r2_reg  <= '0;
            d1_reg  <= modulus;
            d2_reg  <= size;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
        end
    end

    assign done     = done_reg;
    assign rem_seen = r1_reg;
    assign rem_size = r2_reg;

endmodule

`default_nettype wire

@@ design/reservoir_sampler.sv @@
// reservoir sampler (algorithm r): control sequencer, slot memory and output
// register; uses rs_pkg, rs_twister, rs_divider
// offer while filling: tag written to its slot, result emitted; later offers
//   pass through twister read-modify-write, load into the remainder unit, remainder
//   unit, write-back, then emit
// flush: each emitted word is read from the slot memory, one word if empty
// one item at a time; a new item is taken while the last word waits in out reg
// reset and each rng_seed write start a seeding pass over all 624 state words, no item taken
`timescale 1ns / 1ps
`default_nettype none

module reservoir_sampler (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [31:0]                cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       op,
    input  wire logic [rs_pkg::TAG_W-1:0]   item_tag,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            kept,
    output logic      [rs_pkg::SLOT_W-1:0]  slot,
    output logic      [rs_pkg::TAG_W-1:0]   sample_tag,
    output logic                            valid_res,
    output logic                            last
);
    import rs_pkg::*;

    logic [TAG_W-1:0] slot_mem [SLOTS];
    logic [TAG_W-1:0] slot_rd_reg;

    ctrl_state_t       state_reg, state_next;
    logic [SIZE_W-1:0] sample_size_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SIZE_W-1:0] n_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              pend_kept_reg;
    logic [SLOT_W-1:0] pend_slot_reg;

    logic              out_valid_reg;
    logic              kept_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TAG_W-1:0]  tag_out_reg;
    logic              valid_res_reg;
    logic              last_reg;

    tw_ctrl_t          tw_ctrl;
    tw_stat_t          tw_stat;
    logic [31:0]       tw_word;
    logic              div_done;
    logic [32:0]       rem_seen;
    logic [SIZE_W-1:0] rem_size;

    logic [SIZE_W-1:0] size_eff;
    logic              filling;
    logic              accept;
    logic              out_free;
    logic              div_kept;
    logic              flush_last;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [TAG_W-1:0]  mem_wdata;

    always_comb
    begin
        priority if (sample_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (sample_size_reg > SIZE_W'(SLOTS))
        begin
            size_eff = SIZE_W'(SLOTS);
        end
        else
        begin
            size_eff = sample_size_reg;
        end
    end

    assign filling    = seen_reg < {25'd0, size_eff};
    assign in_ready   = (state_reg == S_IDLE) && !tw_stat.busy;
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign div_kept   = rem_seen < {26'd0, size_eff};
    assign flush_last = ({1'b0, idx_reg} + 1'b1) == n_reg;

    assign tw_ctrl.seed_load = cfg_we && (cfg_index == REG_RNG_SEED);
    assign tw_ctrl.draw_req  = accept && (op == OP_OFFER) && !filling;

    rs_twister u_twister (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tw_ctrl),
        .seed  (cfg_data),
        .stat  (tw_stat),
        .word  (tw_word)
    );

    rs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tw_stat.word_valid && (state_reg == S_DRAW)),
        .dividend (tw_word),
        .modulus  ({1'b0, seen_reg} + 33'd1),
        .size     (size_eff),
        .done     (div_done),
        .rem_seen (rem_seen),
        .rem_size (rem_size)
    );

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = seen_reg[SLOT_W-1:0];
        mem_wdata  = item_tag;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_OFFER)
                    begin
                        if (filling)
                        begin
                            mem_we     = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_DRAW;
                        end
                    end
                    else if (seen_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FLUSH_RD;
                    end
                end
            end
            S_DRAW:
            begin
                if (tw_stat.word_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = div_kept;
                    mem_waddr  = rem_size[SLOT_W-1:0];
                    mem_wdata  = tag_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH_RD: state_next = S_FLUSH_OUT;
            S_FLUSH_OUT:
            begin
                if (out_free)
                begin
                    state_next = flush_last ? S_IDLE : S_FLUSH_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        slot_rd_reg <= slot_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_size_reg <= SIZE_RESET;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == REG_SAMPLE_SIZE))
            begin
                sample_size_reg <= cfg_data[SIZE_W-1:0];
            end
            if (mem_we || (state_reg == S_DIV && div_done))
            begin
                if (seen_reg != '1)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == S_FLUSH_OUT && out_free)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if ((state_reg == S_EMIT || state_reg == S_FLUSH_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg       <= item_tag;
            n_reg         <= filling ? seen_reg[SIZE_W-1:0] : size_eff;
            pend_kept_reg <= (op == OP_OFFER) && filling;
            pend_slot_reg <= ((op == OP_OFFER) && filling) ? seen_reg[SLOT_W-1:0] : '0;
        end
        if (state_reg == S_DIV && div_done)
        begin
            pend_kept_reg <= div_kept;
            pend_slot_reg <= div_kept ? rem_size[SLOT_W-1:0] : '0;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            kept_reg      <= pend_kept_reg;
            slot_reg      <= pend_slot_reg;
            tag_out_reg   <= '0;
            valid_res_reg <= 1'b0;
            last_reg      <= 1'b1;
        end
        if (state_reg == S_FLUSH_OUT && out_free)
        begin
            kept_reg      <= 1'b0;
            slot_reg      <= idx_reg;
            tag_out_reg   <= slot_rd_reg;
            valid_res_reg <= 1'b1;
            last_reg      <= flush_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kept       = kept_reg;
    assign slot       = slot_reg;
    assign sample_tag = tag_out_reg;
    assign valid_res  = valid_res_reg;
    assign last       = last_reg;

    // remainder result only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder done outside divide wait");

    // random word only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        tw_stat.word_valid |-> (state_reg == S_DRAW))
        else $error("random word outside draw wait");

    // flush index stays inside the count taken at accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH_OUT) |-> (({1'b0, idx_reg} < n_reg) && (n_reg != '0)))
        else $error("flush index beyond sample count");

    // seen counter only moves up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != $past(seen_reg)) |-> (seen_reg == $past(seen_reg) + 1'b1))
        else $error("seen counter jumped");

endmodule

`default_nettype wire
